// File: hw/rtl/gdf_pkg.sv
// Shared types and constants for the gage record deframer.
package gdf_pkg;

  // Record layout
  localparam int unsigned NumGages     = 6;
  localparam int unsigned PayloadBytes = 12;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned SumWidth     = 7;

  localparam logic [PosWidth-1:0] LastPos  = 4'd12;  // checksum byte position
  localparam logic [PosWidth-1:0] SumBytes = 4'd11;  // bytes 0..10 are summed
  localparam int unsigned         ErrBit   = 7;

  // Status code delivered with each record
  typedef enum logic [1:0] {
    StValid     = 2'd0,
    StSensorErr = 2'd1,
    StCsumErr   = 2'd2
  } status_e;

  // One finished record, gages in logical order
  typedef struct packed {
    logic [NumGages-1:0][15:0] gage;
    status_e                   status;
  } rec_t;

endpackage

// File: hw/rtl/gdf_assembler.sv
// Byte position, running checksum and payload store; forms the record on the last byte.
module gdf_assembler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              xfer_i,
  input  logic [7:0]        rx_byte_i,
  output logic              last_o,
  output gdf_pkg::rec_t     rec_o
);

  logic [gdf_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [gdf_pkg::SumWidth-1:0] sum_q, sum_d;
  logic [7:0]                   bytes_q [gdf_pkg::PayloadBytes];
  gdf_pkg::status_e             status;

  // Any position at or past the checksum byte closes the record
  assign last_o = (pos_q >= gdf_pkg::LastPos);

  // Position and running sum
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (xfer_i) begin
      if (last_o) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q < gdf_pkg::SumBytes) begin
          sum_d = sum_q + rx_byte_i[gdf_pkg::SumWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Payload bytes, no reset: all are written before the record closes
  always_ff @(posedge clk_i) begin
    if (xfer_i && !last_o) begin
      bytes_q[pos_q] <= rx_byte_i;
    end
  end

  // Error bit wins over the checksum compare
  always_comb begin
    if (rx_byte_i[gdf_pkg::ErrBit]) begin
      status = gdf_pkg::StSensorErr;
    end else if (rx_byte_i[gdf_pkg::SumWidth-1:0] != sum_q) begin
      status = gdf_pkg::StCsumErr;
    end else begin
      status = gdf_pkg::StValid;
    end
  end

  // Wire order is gage0, gage2, gage4, gage1, gage3, gage5; zero on a bad record
  always_comb begin
    rec_o.status = status;
    rec_o.gage   = '0;
    if (status == gdf_pkg::StValid) begin
      rec_o.gage[0] = {bytes_q[1],  bytes_q[0]};
      rec_o.gage[1] = {bytes_q[7],  bytes_q[6]};
      rec_o.gage[2] = {bytes_q[3],  bytes_q[2]};
      rec_o.gage[3] = {bytes_q[9],  bytes_q[8]};
      rec_o.gage[4] = {bytes_q[5],  bytes_q[4]};
      rec_o.gage[5] = {bytes_q[11], bytes_q[10]};
    end
  end

  // Position never runs past the checksum byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= gdf_pkg::LastPos)
    else $error("byte position out of range");

  // Closing a record restarts position and sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer_i && last_o) |=> (pos_q == '0 && sum_q == '0))
    else $error("record boundary did not clear state");

endmodule

// File: hw/rtl/gdf_out_reg.sv
// Result register with valid/ready toward the consumer.
module gdf_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  gdf_pkg::rec_t rec_i,
  output logic          valid_o,
  input  logic          ready_i,
  output gdf_pkg::rec_t rec_o
);

  logic          valid_q, valid_d;
  gdf_pkg::rec_t rec_q;

  // Fill on load, drain on transfer
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

  // A held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_i && valid_q && !ready_i))
    else $error("result overwritten before transfer");

endmodule

// File: hw/rtl/gage_record_deframer_top.sv
// Top level of the gage record deframer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | rx_byte_i
//  out     | source    | out_valid_o/out_ready_i | gage0_o..gage5_o, record_status_o
//
// One byte is taken every cycle while in_ready_o is high; the result of a record
// appears in the output register the cycle after its thirteenth byte is transferred.
// in_ready_o drops only on a checksum byte while the previous result is still
// held and out_ready_i is low; payload bytes are taken regardless.
// Reset clears the byte position, running sum and output valid.
module gage_record_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] gage0_o,
  output logic [15:0] gage1_o,
  output logic [15:0] gage2_o,
  output logic [15:0] gage3_o,
  output logic [15:0] gage4_o,
  output logic [15:0] gage5_o,
  output logic [1:0]  record_status_o
);

  logic          xfer;
  logic          last;
  gdf_pkg::rec_t rec_asm;
  gdf_pkg::rec_t rec_out;

  // Stall only when a result would land on a held one
  assign in_ready_o = !last || !out_valid_o || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;

  gdf_assembler u_asm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .xfer_i    (xfer),
    .rx_byte_i (rx_byte_i),
    .last_o    (last),
    .rec_o     (rec_asm)
  );

  gdf_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (xfer && last),
    .rec_i   (rec_asm),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rec_o   (rec_out)
  );

  assign gage0_o         = rec_out.gage[0];
  assign gage1_o         = rec_out.gage[1];
  assign gage2_o         = rec_out.gage[2];
  assign gage3_o         = rec_out.gage[3];
  assign gage4_o         = rec_out.gage[4];
  assign gage5_o         = rec_out.gage[5];
  assign record_status_o = rec_out.status;

endmodule
